>>> rtl/sct_pkg.sv
// Shared constants, types and helper functions for the sensor change throttle.
`timescale 1ns / 1ps
`default_nettype none
package sct_pkg;

  localparam int MAX_OBJECTS = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);
  localparam int VAL_W       = 32;
  localparam int CODE_W      = 3;
  localparam int HOLD_W      = 8;
  localparam int ACT_W       = 2;
  localparam int CFG_W       = 5;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_UPDATE   = 2'd1,
    ACT_SET_FREQ = 2'd2,
    ACT_UNUSED   = 2'd3
  } action_t;

  localparam logic [CODE_W-1:0] FREQ_OFF       = 3'd0;
  localparam logic [CODE_W-1:0] FREQ_IMMEDIATE = 3'd1;

  function automatic logic [HOLD_W-1:0] reload_for(input logic [CODE_W-1:0] code);
    logic [HOLD_W-1:0] r;
    case (code)
      3'd2:    r = 8'd1;
      3'd3:    r = 8'd2;
      3'd4:    r = 8'd4;
      3'd5:    r = 8'd20;
      3'd6:    r = 8'd100;
      3'd7:    r = 8'd200;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/sct_if.sv
// Valid/ready channel interfaces for input items, notices and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface sct_in_if import sct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [IDX_W-1:0]  object_index;
  logic [VAL_W-1:0]  sensor_value;
  logic [CODE_W-1:0] frequency_code;

  modport source (output valid, action, object_index, sensor_value, frequency_code,
                  input ready);
  modport sink   (input valid, action, object_index, sensor_value, frequency_code,
                  output ready);
endinterface

interface sct_out_if import sct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] notice_index;
  logic [VAL_W-1:0] notice_value;
  logic             last;

  modport source (output valid, notice_index, notice_value, last, input ready);
  modport sink   (input valid, notice_index, notice_value, last, output ready);
endinterface

interface sct_cfg_if import sct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> rtl/sensor_change_throttle.sv
// Sensor change throttle top level: per-object store and tick walker.
// Update / set-frequency: handled in S_IDLE; an immediate notice also passes through S_FLUSH.
// Tick: S_WALK visits the active objects in turn, then S_FLUSH sends any held notice;
//   a notice may wait on the output.
// The single step unit visits one object per cycle unless a stalled output holds it;
//   in_ch.ready is low during a walk. Synchronous active-low reset clears codes, pending
//   flags, holdoff counts and sets the active count to 16.
`timescale 1ns / 1ps
`default_nettype none
module sensor_change_throttle import sct_pkg::*; (
  input  wire     clk,
  input  wire     rst_n,
  sct_in_if.sink  in_ch,
  sct_out_if.source out_ch,
  sct_cfg_if.sink cfg_ch
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FLUSH} state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CFG_W-1:0]   active_r;
  logic               cand_v_r, cand_v_nxt;
  logic [IDX_W-1:0]   cand_idx_r, cand_idx_nxt;
  logic [VAL_W-1:0]   cand_val_r, cand_val_nxt;
  logic               out_v_r, out_v_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [VAL_W-1:0]   out_val_r, out_val_nxt;
  logic               out_last_r, out_last_nxt;

  logic [VAL_W-1:0]   sensor_r [MAX_OBJECTS];
  logic [CODE_W-1:0]  freq_r   [MAX_OBJECTS];
  logic               pend_r   [MAX_OBJECTS];
  logic [HOLD_W-1:0]  hold_r   [MAX_OBJECTS];

  logic [CNT_W-1:0]   n_use;
  logic               in_acc, out_free;
  logic [IDX_W-1:0]   rd_idx;
  logic [CODE_W-1:0]  rd_freq;
  logic [HOLD_W-1:0]  rd_hold;
  logic               rd_pend;
  logic               in_range;

  logic               wr_sensor, wr_freq, pend_set, pend_clr, hold_wr;
  logic [HOLD_W-1:0]  hold_val;

  assign n_use    = (active_r > CFG_W'(MAX_OBJECTS)) ? CNT_W'(MAX_OBJECTS) : CNT_W'(active_r);
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_v_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign rd_idx  = (state_r == S_WALK) ? cnt_r[IDX_W-1:0] : in_ch.object_index;
  assign rd_freq = freq_r[rd_idx];
  assign rd_hold = hold_r[rd_idx];
  assign rd_pend = pend_r[rd_idx];
  assign in_range = CNT_W'(in_ch.object_index) < n_use;

  assign out_ch.valid        = out_v_r;
  assign out_ch.notice_index = out_idx_r;
  assign out_ch.notice_value = out_val_r;
  assign out_ch.last         = out_last_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cand_v_nxt   = cand_v_r;
    cand_idx_nxt = cand_idx_r;
    cand_val_nxt = cand_val_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_idx_nxt  = out_idx_r;
    out_val_nxt  = out_val_r;
    out_last_nxt = out_last_r;
    wr_sensor    = 1'b0;
    wr_freq      = 1'b0;
    pend_set     = 1'b0;
    pend_clr     = 1'b0;
    hold_wr      = 1'b0;
    hold_val     = rd_hold - HOLD_W'(1);
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.action == ACT_TICK) begin
            cnt_nxt   = '0;
            state_nxt = S_WALK;
          end else if (in_range && in_ch.action == ACT_UPDATE) begin
            wr_sensor = 1'b1;
            pend_set  = rd_freq > FREQ_IMMEDIATE;
            if (rd_freq == FREQ_IMMEDIATE) begin
              cand_v_nxt   = 1'b1;
              cand_idx_nxt = in_ch.object_index;
              cand_val_nxt = in_ch.sensor_value;
              state_nxt    = S_FLUSH;
            end
          end else if (in_range && in_ch.action == ACT_SET_FREQ) begin
            wr_freq = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (cnt_r == n_use) begin
          state_nxt = cand_v_r ? S_FLUSH : S_IDLE;
        end else if (rd_hold != '0) begin
          hold_wr = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (rd_pend) begin
          if (!cand_v_r || out_free) begin
            if (cand_v_r) begin
              out_v_nxt    = 1'b1;
              out_idx_nxt  = cand_idx_r;
              out_val_nxt  = cand_val_r;
              out_last_nxt = 1'b0;
            end
            cand_v_nxt   = 1'b1;
            cand_idx_nxt = rd_idx;
            cand_val_nxt = sensor_r[rd_idx];
            pend_clr     = 1'b1;
            hold_wr      = 1'b1;
            hold_val     = reload_for(rd_freq);
            cnt_nxt      = cnt_r + CNT_W'(1);
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_idx_nxt  = cand_idx_r;
          out_val_nxt  = cand_val_r;
          out_last_nxt = 1'b1;
          cand_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      active_r <= ACTIVE_RESET;
      cand_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < MAX_OBJECTS; i++) begin
        freq_r[i] <= FREQ_OFF;
        pend_r[i] <= 1'b0;
        hold_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      cand_v_r <= cand_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_ch.valid && cfg_ch.ready) active_r <= cfg_ch.data;
      if (wr_freq)  freq_r[rd_idx] <= in_ch.frequency_code;
      if (pend_set) pend_r[rd_idx] <= 1'b1;
      if (pend_clr) pend_r[rd_idx] <= 1'b0;
      if (hold_wr)  hold_r[rd_idx] <= hold_val;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    cand_idx_r <= cand_idx_nxt;
    cand_val_r <= cand_val_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    if (wr_sensor) sensor_r[rd_idx] <= in_ch.sensor_value;
  end

endmodule
`default_nettype wire

>>> rtl/sct_checker.sv
// Port-level checks for the sensor change throttle, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sct_checker import sct_pkg::*; (
  input wire             clk,
  input wire             rst_n,
  input wire             in_valid,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input wire [IDX_W-1:0] out_idx,
  input wire [VAL_W-1:0] out_val,
  input wire             out_last
);

  // stalled notice holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_idx) && $stable(out_val)
      && $stable(out_last))
    else $error("stalled notice changed");

  // no notice appears in the cycle right after an item is taken
  a_no_early_notice: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("notice rose straight after item accepted");

  // more notices to follow: the walk is still busy
  a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready while tick notices outstanding");

endmodule

bind sensor_change_throttle sct_checker u_sct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_idx   (out_ch.notice_index),
  .out_val   (out_ch.notice_value),
  .out_last  (out_ch.last)
);
`default_nettype wire
